/* rtl/lhto_pkg.sv */
`default_nettype none
package lhto_pkg;

  typedef enum logic [1:0] {
    ACT_WRITE    = 2'd0,
    ACT_HIT      = 2'd1,
    ACT_VALIDATE = 2'd2,
    ACT_NONE     = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_DISABLED     = 3'd1,
    ST_OBSCURED     = 3'd2,
    ST_NO_SURFACE   = 3'd3,
    ST_BAD_GEOMETRY = 3'd4,
    ST_STALE        = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CFG_ENABLED     = 2'd0,
    CFG_LAYER_COUNT = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_FIND,
    BK_COVER,
    BK_DONE
  } bk_state_t;

  localparam logic [2:0] F_VISIBLE = 3'b001;
  localparam logic [2:0] F_INPUT   = 3'b010;
  localparam logic [2:0] F_FRAME   = 3'b100;

  typedef struct packed {
    logic [1:0]  action;
    logic [3:0]  layer_index;
    logic [15:0] surface_id;
    logic [15:0] owner;
    logic [1:0]  role;
    logic [2:0]  flags;
    logic [1:0]  trust;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic [15:0] width;
    logic [15:0] height;
    logic [31:0] frame_seq;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] hit_surface;
    logic [15:0] hit_owner;
    logic [1:0]  hit_role;
    logic [1:0]  hit_trust;
    logic [15:0] hit_width;
    logic [15:0] hit_height;
    logic [31:0] hit_frame_seq;
    logic [15:0] local_x;
    logic [15:0] local_y;
  } result_t;

  // classified job handed from front to back
  typedef struct packed {
    logic        scan;      // needs a table scan
    logic        validate;
    logic [2:0]  status;    // final status when no scan
    item_t       item;
  } job_t;

  function automatic logic [1:0] trust_of_role(input logic [1:0] r);
    unique case (r)
      2'd2:    trust_of_role = 2'd1;
      2'd3:    trust_of_role = 2'd2;
      default: trust_of_role = 2'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

/* rtl/lhto_if.sv */
`default_nettype none
interface lhto_if #(parameter int W = 1);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/lhto_ram.sv */
`default_nettype none
module lhto_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* rtl/lhto_front.sv */
`default_nettype none
module lhto_front import lhto_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  enabled,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire item_t in_item,
  output logic       q_valid,
  input  wire logic  q_ready,
  output job_t       q_job
);
  // two-entry queue
  job_t       buf0, buf1;
  logic [1:0] cnt;
  job_t       cls;
  logic       push, pop;
  logic signed [32:0] lx, ly;

  always_comb begin
    lx = 33'(in_item.coord_x);
    ly = 33'(in_item.coord_y);
    cls = '0;
    cls.item = in_item;
    cls.status = ST_OK;
    unique case (action_t'(in_item.action))
      ACT_WRITE: cls.scan = 1'b0;
      ACT_HIT: begin
        if (!enabled) cls.status = ST_DISABLED;
        else cls.scan = 1'b1;
      end
      ACT_VALIDATE: begin
        cls.validate = 1'b1;
        if (!enabled) cls.status = ST_DISABLED;
        else if (in_item.surface_id == '0 || in_item.width == '0 ||
                 in_item.height == '0 || lx < 0 || ly < 0 ||
                 lx >= $signed({17'd0, in_item.width}) ||
                 ly >= $signed({17'd0, in_item.height}))
          cls.status = ST_STALE;
        else if (in_item.flags[1:0] != 2'b00) cls.status = ST_OBSCURED;
        else cls.scan = 1'b1;
      end
      default: cls.scan = 1'b0;
    endcase
  end

  assign in_ready = (cnt != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign q_job    = buf0;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      buf0 <= (cnt == 2'd2) ? buf1 : cls;
      if (push && cnt == 2'd2) buf1 <= cls;
    end else if (push) begin
      if (cnt == 2'd0) buf0 <= cls;
      else buf1 <= cls;
    end
  end
endmodule
`default_nettype wire

/* rtl/lhto_back.sv */
`default_nettype none
module lhto_back import lhto_pkg::*; #(
  parameter int MAX_LAYERS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [4:0] layer_count,
  input  wire logic       q_valid,
  output logic            q_ready,
  input  wire job_t       q_job,
  output logic            out_valid,
  input  wire logic       out_ready,
  output result_t         out_res
);
  localparam int IW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CW = $clog2(MAX_LAYERS + 1);
  localparam int EW = 36 + 3 + 64 + 32 + 32;

  bk_state_t state, state_next;
  job_t      job;
  logic [CW-1:0] n;
  logic [CW-1:0] ptr;        // entry being requested
  logic          rd_pend;    // read data valid this cycle
  logic [CW-1:0] rd_ptr;
  logic [EW-1:0] rdata, tdata;
  logic [2:0]    st;
  logic          covered;
  logic          we;
  logic [EW-1:0] wdata;
  logic [IW-1:0] raddr;
  logic          cnt_big;

  logic [15:0] e_id, e_own, t_own, t_id;
  logic [1:0]  e_role, e_trust;
  logic [2:0]  e_flags;
  logic signed [31:0] e_x, e_y, t_x, t_y;
  logic [15:0] e_w, e_h, t_w, t_h;
  logic [31:0] e_seq;
  logic signed [33:0] px, py;
  logic signed [33:0] e_r, e_b, t_r, t_b;
  logic e_cont, e_ovl, e_cov;
  logic [15:0] sz_w, sz_h;

  assign {e_id, e_own, e_role, e_trust, e_flags, e_x, e_y, e_w, e_h, e_seq} = rdata;
  assign t_id  = tdata[EW-1 -: 16];
  assign t_own = tdata[EW-17 -: 16];
  assign t_x   = tdata[EW-40 -: 32];
  assign t_y   = tdata[EW-72 -: 32];
  assign t_w   = tdata[EW-104 -: 16];
  assign t_h   = tdata[EW-120 -: 16];

  assign sz_w = q_job.item.width  & 16'((32'd1 << SIZE_BITS) - 32'd1);
  assign sz_h = q_job.item.height & 16'((32'd1 << SIZE_BITS) - 32'd1);
  assign we = (state == BK_IDLE) && q_valid && !q_job.scan && !q_job.validate &&
              (action_t'(q_job.item.action) == ACT_WRITE) &&
              ({28'd0, q_job.item.layer_index} < 32'(MAX_LAYERS));
  assign wdata = {q_job.item.surface_id, q_job.item.owner, q_job.item.role,
                  q_job.item.trust, q_job.item.flags, q_job.item.coord_x,
                  q_job.item.coord_y, sz_w, sz_h, q_job.item.frame_seq};
  assign raddr = ptr[IW-1:0];
  assign cnt_big = ({27'd0, layer_count} > 32'(MAX_LAYERS));

  lhto_ram #(.WIDTH(EW), .DEPTH(MAX_LAYERS)) u_ram (
    .clk(clk), .we(we), .waddr(IW'(q_job.item.layer_index)), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // point being tested: query point or target origin plus hit-local point
  always_comb begin
    if (job.validate) begin
      px = 34'(t_x) + 34'(job.item.coord_x);
      py = 34'(t_y) + 34'(job.item.coord_y);
    end else begin
      px = 34'(job.item.coord_x);
      py = 34'(job.item.coord_y);
    end
  end

  logic [15:0] own_ref;
  assign own_ref = job.validate ? job.item.owner : t_own;

  assign e_r = 34'(e_x) + $signed({18'd0, e_w});
  assign e_b = 34'(e_y) + $signed({18'd0, e_h});
  assign t_r = 34'(t_x) + $signed({18'd0, t_w});
  assign t_b = 34'(t_y) + $signed({18'd0, t_h});

  always_comb begin
    e_cont = (34'(job.item.coord_x) >= 34'(e_x)) && (34'(job.item.coord_y) >= 34'(e_y)) &&
             (34'(job.item.coord_x) < e_r) &&
             (34'(job.item.coord_y) < e_b);
    e_cov  = (px >= 34'(e_x)) && (py >= 34'(e_y)) &&
             (px < e_r) && (py < e_b);
    e_ovl  = (34'(e_x) < t_r) && (34'(t_x) < e_r) &&
             (34'(e_y) < t_b) && (34'(t_y) < e_b);
  end

  logic find_hit, find_end, cov_end;
  always_comb begin
    if (job.validate)
      find_hit = (e_id == job.item.surface_id);
    else
      find_hit = (e_flags == (F_VISIBLE | F_INPUT | F_FRAME)) && e_cont;
    find_end = rd_pend && (find_hit || (job.validate ? (rd_ptr == n - 1'b1) :
                                                        (rd_ptr == '0)));
    cov_end  = !rd_pend && (ptr >= n);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:
        if (q_valid) begin
          if (q_job.scan && n != '0) state_next = BK_FIND;
          else state_next = BK_DONE;
        end
      BK_FIND: if (find_end) state_next = find_hit ? BK_COVER : BK_DONE;
      BK_COVER: if (cov_end) state_next = BK_DONE;
      BK_DONE: if (out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  assign q_ready   = (state == BK_IDLE);
  assign out_valid = (state == BK_DONE);

  logic [15:0] vlx, vly;
  assign vlx = 16'(job.item.coord_x - t_x);
  assign vly = 16'(job.item.coord_y - t_y);

  always_comb begin
    out_res = '0;
    out_res.status = st;
    if (st == ST_OK && !job.validate && job.scan) begin
      out_res.hit_surface   = tdata[EW-1 -: 16];
      out_res.hit_owner     = t_own;
      out_res.hit_role      = tdata[EW-33 -: 2];
      out_res.hit_trust     = tdata[EW-35 -: 2];
      out_res.hit_width     = t_w;
      out_res.hit_height    = t_h;
      out_res.hit_frame_seq = tdata[31:0];
      out_res.local_x       = vlx;
      out_res.local_y       = vly;
    end
  end

  logic match_ok;
  assign match_ok = (e_own == job.item.owner) && (e_role == job.item.role) &&
                    (e_flags == (F_VISIBLE | F_INPUT | F_FRAME)) &&
                    (e_seq == job.item.frame_seq) && (e_w == job.item.width) &&
                    (e_h == job.item.height) && (trust_of_role(e_role) == job.item.trust);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= BK_IDLE;
      rd_pend <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        BK_IDLE: rd_pend <= 1'b0;
        BK_FIND: begin
          if (find_end) rd_pend <= 1'b0;
          else rd_pend <= 1'b1;
        end
        BK_COVER: rd_pend <= (ptr < n);
        default: rd_pend <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr <= ptr;
    unique case (state)
      BK_IDLE: begin
        n <= cnt_big ? CW'(MAX_LAYERS) : CW'(layer_count);
        if (q_valid) begin
          job     <= q_job;
          st      <= q_job.status;
          covered <= 1'b0;
          if (q_job.scan) st <= q_job.validate ? ST_STALE : ST_NO_SURFACE;
          ptr <= q_job.validate ? '0 :
                 (cnt_big ? CW'(MAX_LAYERS - 1) : CW'(layer_count - 5'd1));
        end
      end
      BK_FIND: begin
        if (find_end && find_hit) begin
          tdata <= rdata;
          if (job.validate) st <= match_ok ? ST_OK : ST_STALE;
          else st <= ST_OK;
          ptr <= rd_ptr + 1'b1;
          if (job.validate && !match_ok) ptr <= n;
        end else begin
          ptr <= job.validate ? ptr + 1'b1 : ptr - 1'b1;
        end
      end
      BK_COVER: begin
        if (ptr < n) ptr <= ptr + 1'b1;
        if (rd_pend && e_flags[0] && e_flags[2] && e_own != own_ref && (e_cov || e_ovl))
          covered <= 1'b1;
        if (cov_end && st == ST_OK) begin
          if (covered) st <= ST_OBSCURED;
          else if (!job.validate && t_id == '0) st <= ST_BAD_GEOMETRY;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/layer_hit_test_with_obscuration.sv */
// The back end handles one item at a time and takes no new item until its result has
// been accepted; a scan is paced by the single read port of the layer table.
// A 2-beat queue decouples input.
// Reset (rst, synchronous): clears control, enabled and layer_count; table undefined.
`default_nettype none
module layer_hit_test_with_obscuration import lhto_pkg::*; #(
  parameter int MAX_LAYERS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  lhto_if.sink      in_ch,
  lhto_if.source    out_ch,
  lhto_if.sink      cfg
);
  logic       enabled;
  logic [4:0] layer_count;
  logic       q_valid, q_ready;
  job_t       q_job;
  item_t      in_item;
  result_t    res;
  logic [1:0] cfg_index;
  logic [31:0] cfg_value;

  assign cfg.ready = 1'b1;
  assign cfg_index = cfg.data[33:32];
  assign cfg_value = cfg.data[31:0];
  always_ff @(posedge clk) begin
    if (rst) begin
      enabled     <= 1'b0;
      layer_count <= '0;
    end else if (cfg.valid) begin
      if (cfg_index == CFG_ENABLED) enabled <= cfg_value[0];
      else if (cfg_index == CFG_LAYER_COUNT) layer_count <= cfg_value[4:0];
    end
  end

  assign in_item = in_ch.data;

  lhto_front u_front (
    .clk(clk), .rst(rst), .enabled(enabled),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item(in_item),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job)
  );

  lhto_back #(.MAX_LAYERS(MAX_LAYERS), .SIZE_BITS(SIZE_BITS)) u_back (
    .clk(clk), .rst(rst), .layer_count(layer_count),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
  );
  assign out_ch.data = res;

  a_count_reset: assert property (@(posedge clk) rst |=> layer_count == '0 && !enabled)
    else $error("config not cleared by reset");
  a_q_ready: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !q_ready) else $error("back accepts while result pending");
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> res.status <= ST_STALE) else $error("bad status code");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
endmodule
`default_nettype wire
